FILE: rtl/greedy_box_suppression_assert.svh
// Assertion macros used by the checker file
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GBS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GBS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gbs_pkg.sv
// Types and constants of the greedy box suppression block
`default_nettype none

package gbs_pkg;

    localparam int COORD_W         = 16;
    localparam int INDEX_W         = 14;
    localparam int TOTAL_W         = 8;
    localparam int AREA_W          = 32;
    localparam int ENTRY_W         = 4 * COORD_W + AREA_W;
    localparam logic [15:0] THRESHOLD_RESET = 16'd45875;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 first;
        logic [COORD_W-1:0]   left;
        logic [COORD_W-1:0]   top;
        logic [COORD_W-1:0]   width;
        logic [COORD_W-1:0]   height;
        logic [AREA_W-1:0]    area;
        logic [INDEX_W-1:0]   index;
    } gbs_item_t;

    typedef struct packed {
        logic                 keep;
        logic [INDEX_W-1:0]   box_index;
        logic [TOTAL_W-1:0]   kept_total;
        logic                 list_full;
    } gbs_result_t;

endpackage

`default_nettype wire

FILE: rtl/gbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/gbs_front.sv
// Front end: takes boxes, numbers them within the set, works out the area
`default_nettype none

module gbs_front
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = 16384
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               first_of_set,
    input  wire logic [COORD_W-1:0] box_left,
    input  wire logic [COORD_W-1:0] box_top,
    input  wire logic [COORD_W-1:0] box_width,
    input  wire logic [COORD_W-1:0] box_height,
    input  wire logic               q_full,
    output logic                    q_push,
    output gbs_item_t               q_item
);

    localparam int PW = $clog2(MAX_BOXES);

    logic               stage_valid_reg, stage_valid_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      idx;
    logic               accept;
    logic               first_reg;
    logic [COORD_W-1:0] left_reg, top_reg, width_reg, height_reg;
    logic [INDEX_W-1:0] index_reg;

    assign busy   = stage_valid_reg & q_full;
    assign accept = start & ~busy;
    assign q_push = stage_valid_reg & ~q_full;

    always_comb
    begin
        idx      = first_of_set ? '0 : pos_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (idx < PW'(MAX_BOXES - 1)) ? idx + 1'b1 : idx;
        end
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            pos_reg         <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg  <= first_of_set;
            left_reg   <= box_left;
            top_reg    <= box_top;
            width_reg  <= box_width;
            height_reg <= box_height;
            index_reg  <= INDEX_W'(idx);
        end
    end

    always_comb
    begin
        q_item.first  = first_reg;
        q_item.left   = left_reg;
        q_item.top    = top_reg;
        q_item.width  = width_reg;
        q_item.height = height_reg;
        q_item.area   = AREA_W'(width_reg) * AREA_W'(height_reg);
        q_item.index  = index_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/gbs_queue.sv
// Short queue of numbered boxes between front and back ends
`default_nettype none

module gbs_queue
    import gbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire gbs_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output gbs_item_t      pop_item,
    output logic           empty
);

    gbs_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   fill_reg, fill_next;

    assign full     = (fill_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gbs_back.sv
// Back end: scans the kept list through an overlap pipe and decides each box
`default_nettype none

module gbs_back
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] threshold,
    input  wire logic        q_empty,
    input  wire gbs_item_t   q_item,
    output logic             q_pop,
    output logic             done,
    output gbs_result_t      result
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               sup_reg, sup_next;
    logic               done_reg, done_next;
    gbs_result_t        result_reg, result_next;
    gbs_item_t          item_reg;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic               s1_valid_next;
    logic [15:0]        dx2_reg, dy2_reg;
    logic               ov2_reg;
    logic [AREA_W-1:0]  karea2_reg, karea3_reg;
    logic [AREA_W-1:0]  inter3_reg, inter4_reg, inter5_reg;
    logic [AREA_W:0]    uni4_reg;
    logic [48:0]        prod5_reg;
    logic               uni_zero5_reg;

    logic               rd_en;
    logic               wr_en;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    logic               hit;
    logic               pipe_busy;

    logic signed [17:0] l18, t18, r18, b18, kl18, kt18, kr18, kb18;
    logic signed [17:0] x0, x1, y0, y1;
    logic signed [18:0] dx19, dy19;

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (k_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign wdata = {item_reg.area, item_reg.height, item_reg.width, item_reg.top,
                    item_reg.left};

    always_comb
    begin
        l18  = 18'(signed'(item_reg.left));
        t18  = 18'(signed'(item_reg.top));
        r18  = l18 + signed'({2'b00, item_reg.width});
        b18  = t18 + signed'({2'b00, item_reg.height});
        kl18 = 18'(signed'(rdata[15:0]));
        kt18 = 18'(signed'(rdata[31:16]));
        kr18 = kl18 + signed'({2'b00, rdata[47:32]});
        kb18 = kt18 + signed'({2'b00, rdata[63:48]});
        x0   = (l18 > kl18) ? l18 : kl18;
        x1   = (r18 < kr18) ? r18 : kr18;
        y0   = (t18 > kt18) ? t18 : kt18;
        y1   = (b18 < kb18) ? b18 : kb18;
        dx19 = 19'(x1) - 19'(x0);
        dy19 = 19'(y1) - 19'(y0);
    end

    assign hit       = s5_valid_reg & ~uni_zero5_reg & ({1'b0, inter5_reg, 16'b0} > prod5_reg);
    assign pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg | s5_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        sup_next      = sup_reg | hit;
        done_next     = 1'b0;
        result_next   = result_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        s1_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    k_next     = '0;
                    sup_next   = 1'b0;
                    state_next = ST_SCAN;
                    if (q_item.first)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (k_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    s1_valid_next = 1'b1;
                    k_next        = k_reg + 1'b1;
                end
                else if (!pipe_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                result_next.keep      = 1'b0;
                result_next.list_full = 1'b0;
                if (!sup_reg)
                begin
                    if (count_reg < CW'(MAX_KEPT))
                    begin
                        wr_en                 = 1'b1;
                        count_next            = count_reg + 1'b1;
                        result_next.keep      = 1'b1;
                    end
                    else
                    begin
                        result_next.list_full = 1'b1;
                    end
                end
                result_next.box_index  = item_reg.index;
                result_next.kept_total = TOTAL_W'(count_next);
                done_next              = 1'b1;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            sup_reg      <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            sup_reg      <= sup_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        dx2_reg       <= dx19[15:0];
        dy2_reg       <= dy19[15:0];
        ov2_reg       <= (dx19 > 19'sd0) && (dy19 > 19'sd0);
        karea2_reg    <= rdata[ENTRY_W-1:4*COORD_W];
        inter3_reg    <= ov2_reg ? AREA_W'(dx2_reg) * AREA_W'(dy2_reg) : '0;
        karea3_reg    <= karea2_reg;
        uni4_reg      <= {1'b0, item_reg.area} + {1'b0, karea3_reg} - {1'b0, inter3_reg};
        inter4_reg    <= inter3_reg;
        prod5_reg     <= {33'b0, threshold} * {16'b0, uni4_reg};
        inter5_reg    <= inter4_reg;
        uni_zero5_reg <= (uni4_reg == '0);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/greedy_box_suppression.sv
// Top level of the greedy box suppression block
//
//  channel   handshake               payload
//  input     start / busy            first_of_set, box_left, box_top, box_width, box_height
//  result    done (one-cycle strobe) keep, box_index, kept_total, list_full
//  config    cfg_valid / cfg_ready   cfg_data (iou_threshold)
//
//  A box holds the back end while it is popped, checked by one kept-list RAM read per
//  kept box through the overlap pipe, the pipe is seen drained, and the decision is
//  made; done follows.
//  The front end and a two-entry queue take up to three more boxes meanwhile.
//  Reset clears counters and the queue and loads the threshold with 45875;
//  the kept-list RAM is not cleared. done cannot be held off by the receiver.
`default_nettype none

module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT  = 128,
    parameter int MAX_BOXES = 16384
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      first_of_set,
    input  wire logic signed [COORD_W-1:0] box_left,
    input  wire logic signed [COORD_W-1:0] box_top,
    input  wire logic        [COORD_W-1:0] box_width,
    input  wire logic        [COORD_W-1:0] box_height,
    output logic                           done,
    output logic                           keep,
    output logic             [INDEX_W-1:0] box_index,
    output logic             [TOTAL_W-1:0] kept_total,
    output logic                           list_full,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic        [15:0]        cfg_data
);

    logic        [15:0] iou_threshold_reg;
    logic               q_push, q_pop, q_full, q_empty;
    gbs_item_t          push_item, pop_item;
    gbs_result_t        result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            iou_threshold_reg <= cfg_data;
        end
    end

    gbs_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_of_set (first_of_set),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_width    (box_width),
        .box_height   (box_height),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    gbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    gbs_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (iou_threshold_reg),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .done      (done),
        .result    (result)
    );

    assign keep       = result.keep;
    assign box_index  = result.box_index;
    assign kept_total = result.kept_total;
    assign list_full  = result.list_full;

endmodule

`default_nettype wire

FILE: rtl/greedy_box_suppression_chk.sv
// Port-level checker for the greedy box suppression block, with its bind
`default_nettype none

`include "greedy_box_suppression_assert.svh"

module greedy_box_suppression_chk
    import gbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               done,
    input  wire logic               keep,
    input  wire logic [INDEX_W-1:0] box_index,
    input  wire logic [TOTAL_W-1:0] kept_total,
    input  wire logic               list_full
);

    `GBS_ASSERT_IMPLY(a_keep_not_full, done && keep, !list_full, "box kept and flagged full")
    `GBS_ASSERT_IMPLY(a_first_total, done && (box_index == '0), (kept_total[7:1] == 7'd0) && (kept_total[0] == keep), "first box of set has wrong total")
    `GBS_ASSERT_NEXT(a_done_gap, done, !done, "results on consecutive cycles")

endmodule

bind greedy_box_suppression greedy_box_suppression_chk u_chk (.*);

`default_nettype wire

FILE: tb/sv/greedy_box_suppression_tb.sv
// Self-checking testbench for greedy box suppression: box sets checked against a kept-list predictor
module greedy_box_suppression_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int MAX_KEPT         = 128;
    localparam int MAX_BOXES        = 16384;
    localparam int RUN_LIMIT        = 4_000_000;
    localparam int DRAIN_CYCLES     = 200;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_BOXES      = 115;
    localparam int FILL_BOXES       = MAX_KEPT + 2;
    localparam int SHADOWED_BOXES   = 40;

    typedef struct packed {
        logic               first;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } box_req_t;

    class kept_list_model;
        logic [15:0]  threshold;
        int unsigned  kept_count;
        int unsigned  position;
        longint       kept_left[MAX_KEPT];
        longint       kept_top[MAX_KEPT];
        longint       kept_width[MAX_KEPT];
        longint       kept_height[MAX_KEPT];
        longint       kept_area[MAX_KEPT];
        gbs_result_t  pending[$];
        int           errors;

        function new();
            threshold  = THRESHOLD_RESET;
            kept_count = 0;
            position   = 0;
            errors     = 0;
        endfunction

        function void note_box(logic first, logic [COORD_W-1:0] left, logic [COORD_W-1:0] top,
                               logic [COORD_W-1:0] width, logic [COORD_W-1:0] height);
            longint      nl, nt, nw, nh, area;
            longint      x0, x1, y0, y1, inter, joint;
            bit          hit;
            gbs_result_t verdict;
            nl   = longint'($signed(left));
            nt   = longint'($signed(top));
            nw   = longint'(width);
            nh   = longint'(height);
            area = nw * nh;
            hit  = 1'b0;
            verdict = '0;
            if (first)
            begin
                kept_count = 0;
                position   = 0;
            end
            verdict.box_index = position[INDEX_W-1:0];
            if (position < MAX_BOXES - 1)
                position++;
            for (int k = 0; k < kept_count; k++)
            begin
                x0 = (nl > kept_left[k]) ? nl : kept_left[k];
                x1 = (nl + nw < kept_left[k] + kept_width[k]) ? nl + nw
                                                               : kept_left[k] + kept_width[k];
                y0 = (nt > kept_top[k]) ? nt : kept_top[k];
                y1 = (nt + nh < kept_top[k] + kept_height[k]) ? nt + nh
                                                               : kept_top[k] + kept_height[k];
                inter = 0;
                if (x1 > x0 && y1 > y0)
                    inter = (x1 - x0) * (y1 - y0);
                joint = area + kept_area[k] - inter;
                if (joint != 0 && (inter << 16) > longint'(threshold) * joint)
                    hit = 1'b1;
            end
            if (!hit)
            begin
                if (kept_count < MAX_KEPT)
                begin
                    kept_left[kept_count]   = nl;
                    kept_top[kept_count]    = nt;
                    kept_width[kept_count]  = nw;
                    kept_height[kept_count] = nh;
                    kept_area[kept_count]   = area;
                    kept_count++;
                    verdict.keep = 1'b1;
                end
                else
                begin
                    verdict.list_full = 1'b1;
                end
            end
            verdict.kept_total = kept_count[TOTAL_W-1:0];
            pending.insert(pending.size(), verdict);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(logic got_keep, logic [INDEX_W-1:0] got_index,
                                    logic [TOTAL_W-1:0] got_total, logic got_full);
            gbs_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no box outstanding, expected none, actual %0b %0d %0d %0b",
                         $time, got_keep, got_index, got_total, got_full);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("keep", want.keep, got_keep);
            compare_field("box_index", want.box_index, got_index);
            compare_field("kept_total", want.kept_total, got_total);
            compare_field("list_full", want.list_full, got_full);
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               first_of_set = 1'b0;
    logic [COORD_W-1:0] box_left     = '0;
    logic [COORD_W-1:0] box_top      = '0;
    logic [COORD_W-1:0] box_width    = '0;
    logic [COORD_W-1:0] box_height   = '0;
    logic               done;
    logic               keep;
    logic [INDEX_W-1:0] box_index;
    logic [TOTAL_W-1:0] kept_total;
    logic               list_full;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data     = '0;

    kept_list_model verdicts = new();
    box_req_t       set_history[$];
    int             burst_left  = 4;
    int             cycle_count = 0;

    greedy_box_suppression i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_of_set (first_of_set),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_width    (box_width),
        .box_height   (box_height),
        .done         (done),
        .keep         (keep),
        .box_index    (box_index),
        .kept_total   (kept_total),
        .list_full    (list_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[greedy_box_suppression] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            verdicts.check_verdict(keep, box_index, kept_total, list_full);
    end

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < -32768)
            return 16'h8000;
        if (v > 32767)
            return 16'h7FFF;
        return v[15:0];
    endfunction

    function automatic logic [COORD_W-1:0] clamp_size(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic box_req_t random_box();
        box_req_t b;
        box_req_t r;
        int       pick;
        pick    = $urandom_range(0, 99);
        b.first = ($urandom_range(0, 99) < 3);
        if (pick < 50 && set_history.size() != 0)
        begin
            r        = set_history[$urandom_range(0, set_history.size() - 1)];
            b.left   = clamp_coord(int'($signed(r.left)) + jitter(64));
            b.top    = clamp_coord(int'($signed(r.top)) + jitter(64));
            b.width  = clamp_size(int'(r.width) + jitter(64));
            b.height = clamp_size(int'(r.height) + jitter(64));
        end
        else if (pick < 80)
        begin
            b.left   = clamp_coord(jitter(2000));
            b.top    = clamp_coord(jitter(2000));
            b.width  = 16'($urandom_range(0, 1000));
            b.height = 16'($urandom_range(0, 1000));
        end
        else if (pick < 92)
        begin
            b.left   = 16'($urandom);
            b.top    = 16'($urandom);
            b.width  = 16'($urandom);
            b.height = 16'($urandom);
        end
        else
        begin
            b.left = clamp_coord(jitter(500));
            b.top  = clamp_coord(jitter(500));
            if ($urandom_range(0, 1) == 0)
            begin
                b.width  = '0;
                b.height = 16'($urandom_range(0, 500));
            end
            else
            begin
                b.width  = 16'($urandom_range(0, 500));
                b.height = '0;
            end
        end
        return b;
    endfunction

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 8);
        end
    endtask

    task automatic send_box(box_req_t b);
        start        <= 1'b1;
        first_of_set <= b.first;
        box_left     <= b.left;
        box_top      <= b.top;
        box_width    <= b.width;
        box_height   <= b.height;
        do
            @(posedge clk);
        while (busy);
        verdicts.note_box(b.first, b.left, b.top, b.width, b.height);
        pace_sender();
    endtask

    task automatic wait_idle(int settle);
        start <= 1'b0;
        while (verdicts.pending.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        verdicts.threshold = value;
    endtask

    initial
    begin
        box_req_t    b;
        box_req_t    anchor;
        logic [15:0] limit;
        int          set_len;
        int          sent;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, empty overlaps and zero unions under the reset threshold
        send_box(box_req_t'{1'b1, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF});
        send_box(box_req_t'{1'b0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF});
        send_box(box_req_t'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'd100});
        send_box(box_req_t'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'd100});
        send_box(box_req_t'{1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF});
        send_box(box_req_t'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_box(box_req_t'{1'b1, 16'd0, 16'd0, 16'd256, 16'd256});
        send_box(box_req_t'{1'b0, 16'd128, 16'd0, 16'd256, 16'd256});
        send_box(box_req_t'{1'b0, 16'd16, 16'd0, 16'd256, 16'd256});
        send_box(box_req_t'{1'b0, 16'd256, 16'd0, 16'd256, 16'd256});

        // overlap ratio exactly one half, either side of the threshold
        wait_idle(SETTLE_CYCLES);
        write_threshold(16'd32768);
        send_box(box_req_t'{1'b1, 16'd0, 16'd0, 16'd48, 16'd16});
        send_box(box_req_t'{1'b0, 16'd16, 16'd0, 16'd48, 16'd16});
        wait_idle(SETTLE_CYCLES);
        write_threshold(16'd32767);
        send_box(box_req_t'{1'b1, 16'd0, 16'd0, 16'd48, 16'd16});
        send_box(box_req_t'{1'b0, 16'd16, 16'd0, 16'd48, 16'd16});

        // fill the kept list with disjoint boxes, then overrun it
        wait_idle(SETTLE_CYCLES);
        write_threshold(THRESHOLD_RESET);
        anchor = '0;
        for (int i = 0; i < FILL_BOXES; i++)
        begin
            b.first  = (i == 0);
            b.left   = 16'(-32768 + i * 256);
            b.top    = clamp_coord(jitter(30000));
            b.width  = 16'($urandom_range(1, 255));
            b.height = 16'($urandom_range(1, 4000));
            if (i == 0)
                anchor = b;
            send_box(b);
        end
        anchor.first = 1'b0;
        send_box(anchor);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       limit = 16'hFFFF;
                1:       limit = 16'h0000;
                2:       limit = THRESHOLD_RESET;
                default: limit = 16'($urandom);
            endcase
            wait_idle(SETTLE_CYCLES);
            write_threshold(limit);
            sent = 0;
            while (sent < PHASE_BOXES)
            begin
                set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 180)
                                                      : $urandom_range(1, 30);
                set_history.delete();
                for (int i = 0; i < set_len; i++)
                begin
                    b = random_box();
                    if (i == 0)
                        b.first = 1'b1;
                    if (b.first)
                        set_history.delete();
                    send_box(b);
                    set_history.insert(set_history.size(), b);
                    sent++;
                end
            end
        end

        // a full-frame box under a zero threshold suppresses every later box of its set
        wait_idle(SETTLE_CYCLES);
        write_threshold(16'h0000);
        send_box(box_req_t'{1'b1, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF});
        for (int i = 0; i < SHADOWED_BOXES; i++)
        begin
            b.first  = 1'b0;
            b.left   = clamp_coord(int'($urandom_range(0, 65534)) - 32768);
            b.top    = clamp_coord(int'($urandom_range(0, 65534)) - 32768);
            b.width  = 16'($urandom_range(1, 65535));
            b.height = 16'($urandom_range(1, 65535));
            send_box(b);
        end

        wait_idle(DRAIN_CYCLES);
        if (verdicts.errors == 0 && verdicts.pending.size() == 0)
            $display("[greedy_box_suppression] OK");
        else
            $display("[greedy_box_suppression] ERROR");
        $finish;
    end

endmodule
